/* hdl/htmd_pkg.sv */
// shared types and constants of the huffman table-match decoder
package htmd_pkg;

    localparam int NUM_ENTRIES  = 256;
    localparam int MAX_CODE_LEN = 16;

    localparam int SLOT_W = $clog2(NUM_ENTRIES);
    localparam int SCAN_W = $clog2(NUM_ENTRIES + 1);
    localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int CMP_W  = (MAX_CODE_LEN > 16) ? MAX_CODE_LEN : 16;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [1:0] STATUS_SYMBOL     = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW   = 2'd1;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

    typedef struct packed {
        logic        op;
        logic [7:0]  entry_slot;
        logic [7:0]  entry_symbol;
        logic [15:0] entry_code;
        logic [4:0]  entry_length;
        logic        code_bit;
        logic        last_bit;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] symbol;
    } result_t;

    typedef struct packed {
        logic [7:0]  symbol;
        logic [15:0] code;
        logic [4:0]  length;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* hdl/huffman_table_match_decoder.sv */
// top level of the huffman table-match decoder: control, accumulator and table scan
//
// channel   direction  handshake            payload
// item      in         item_valid/stall     htmd_pkg::item_t
// result    out        result_valid/stall   htmd_pkg::result_t
// cfg       in         cfg_valid/ready      active entry count, 9 bits
//
// a load transaction writes its table slot and valid bit when accepted; a decode
// transaction shifts in one code bit, then scans the active slots with one table
// ram read per slot, and then resolves
// slots read as empty after reset through per-slot valid bits, no clearing pass
// a stalled result waits in the output register; the next transaction
// is taken meanwhile, and a later result holds in resolve until it drains
module huffman_table_match_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  htmd_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output htmd_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [8:0]        cfg_data
);
    import htmd_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_RESOLVE = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [8:0]              active_reg;
    logic [NUM_ENTRIES-1:0]  slot_vld_reg, slot_vld_next;
    logic [MAX_CODE_LEN-1:0] acc_bits_reg, acc_bits_next;
    logic [CNT_W-1:0]        acc_cnt_reg, acc_cnt_next;
    logic                    last_reg, last_next;
    logic [SCAN_W-1:0]       scan_len_reg, scan_len_next;
    logic [SCAN_W-1:0]       issue_reg, issue_next;
    logic                    pend_reg, pend_next;
    logic                    vld_q_reg, vld_q_next;
    logic                    found_reg, found_next;
    logic [7:0]              hit_reg, hit_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg, out_next;

    logic                    accept;
    logic                    load_slot_ok;
    logic                    ram_we;
    logic                    ram_re;
    logic [SLOT_W-1:0]       ram_raddr;
    entry_t                  ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;
    entry_t                  rd_entry;
    logic                    entry_hit;
    logic [SCAN_W-1:0]       scan_len;
    logic                    out_free;

    assign accept       = item_valid && !item_stall;
    assign item_stall   = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign load_slot_ok = (32'(item.entry_slot) < NUM_ENTRIES);
    assign ram_we       = accept && (item.op == OP_LOAD) && load_slot_ok;
    assign ram_re       = (state_reg == ST_SCAN) && (issue_reg != scan_len_reg);
    assign ram_raddr    = issue_reg[SLOT_W-1:0];

    always_comb
    begin
        ram_wdata.symbol = item.entry_symbol;
        ram_wdata.code   = item.entry_code;
        ram_wdata.length = item.entry_length;
    end

    assign scan_len = (32'(active_reg) > NUM_ENTRIES) ? SCAN_W'(NUM_ENTRIES)
                                                      : SCAN_W'(active_reg);

    assign rd_entry  = entry_t'(ram_rdata);
    assign entry_hit = pend_reg && vld_q_reg && (rd_entry.length != 5'd0)
                       && (32'(rd_entry.length) == 32'(acc_cnt_reg))
                       && (CMP_W'(rd_entry.code) == CMP_W'(acc_bits_reg));

    assign out_free = !out_valid_reg || !result_stall;

    htmd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item.entry_slot[SLOT_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        slot_vld_next  = slot_vld_reg;
        acc_bits_next  = acc_bits_reg;
        acc_cnt_next   = acc_cnt_reg;
        last_next      = last_reg;
        scan_len_next  = scan_len_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        vld_q_next     = vld_q_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_LOAD)
                    begin
                        if (load_slot_ok)
                        begin
                            slot_vld_next[item.entry_slot[SLOT_W-1:0]] = 1'b1;
                        end
                    end
                    else
                    begin
                        acc_bits_next = {acc_bits_reg[MAX_CODE_LEN-2:0], item.code_bit};
                        acc_cnt_next  = acc_cnt_reg + CNT_W'(1);
                        last_next     = item.last_bit;
                        scan_len_next = scan_len;
                        issue_next    = '0;
                        found_next    = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (ram_re)
                begin
                    pend_next  = 1'b1;
                    vld_q_next = slot_vld_reg[ram_raddr];
                    issue_next = issue_reg + SCAN_W'(1);
                end
                if (entry_hit)
                begin
                    found_next = 1'b1;
                    hit_next   = rd_entry.symbol;
                end
                if (!ram_re && !pend_reg)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (found_reg || (32'(acc_cnt_reg) >= MAX_CODE_LEN) || last_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        if (found_reg)
                        begin
                            out_next.status = STATUS_SYMBOL;
                            out_next.symbol = hit_reg;
                        end
                        else if (32'(acc_cnt_reg) >= MAX_CODE_LEN)
                        begin
                            out_next.status = STATUS_OVERFLOW;
                            out_next.symbol = 8'd0;
                        end
                        else
                        begin
                            out_next.status = STATUS_INCOMPLETE;
                            out_next.symbol = 8'd0;
                        end
                        acc_bits_next = '0;
                        acc_cnt_next  = '0;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 9'd0;
            slot_vld_reg  <= '0;
            acc_bits_reg  <= '0;
            acc_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_vld_reg  <= slot_vld_next;
            acc_bits_reg  <= acc_bits_next;
            acc_cnt_reg   <= acc_cnt_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
        end
    end

    // payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        scan_len_reg <= scan_len_next;
        issue_reg    <= issue_next;
        vld_q_reg    <= vld_q_next;
        hit_reg      <= hit_next;
        out_reg      <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* hdl/htmd_ram.sv */
// generic single-write, single-read ram with registered read data
module htmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
